>>> hw/rtl/whole_word_substring_counter_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the whole-word substring counter
// Implication checks, same cycle and next cycle, gated off during reset.
// ----------------------------------------------------------------------------
`ifndef WHOLE_WORD_SUBSTRING_COUNTER_TOP_ASSERT_SVH
`define WHOLE_WORD_SUBSTRING_COUNTER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define WWSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wwsc: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define WWSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wwsc: next-cycle check failed");

`endif

>>> hw/rtl/wwsc_pkg.sv
// ----------------------------------------------------------------------------
// wwsc_pkg
// Shared types, constants and helpers of the whole-word substring counter.
// ----------------------------------------------------------------------------
`default_nettype none

package wwsc_pkg;

    localparam int MAX_PATTERN_DEF   = 8;
    localparam int POSITION_BITS_DEF = 16;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PATTERN_W = 64;
    localparam int LEN_W     = 4;
    localparam int WIN_W     = 16;
    localparam int COUNT_W   = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef logic [7:0] t_byte;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES  = 3'd0,
        CFG_PATTERN_LENGTH = 3'd1,
        CFG_WINDOW_START   = 3'd2,
        CFG_WINDOW_END     = 3'd3,
        CFG_END_AT_LENGTH  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic hit;          // pattern of the selected length ends on the newest byte
        logic before_alnum; // byte ahead of that match is a letter or digit
    } t_match;

    function automatic logic is_alnum(t_byte c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/wwsc_match.sv
// ----------------------------------------------------------------------------
// wwsc_match
// Parallel window compare of the byte history against the pattern, one
// comparator row per possible pattern length, plus the before-byte check.
// ----------------------------------------------------------------------------
`default_nettype none

module wwsc_match #(
    parameter int MAX_PATTERN = wwsc_pkg::MAX_PATTERN_DEF
) (
    input  wwsc_pkg::t_byte                  i_hist [MAX_PATTERN+1],
    input  logic [wwsc_pkg::PATTERN_W-1:0]   i_pattern,
    input  logic [wwsc_pkg::LEN_W-1:0]       i_len,
    output wwsc_pkg::t_match                 o_match
);
    import wwsc_pkg::*;

    // slot 0 of the history is the newest byte; pattern byte 0 is the oldest
    always_comb begin
        logic eq;
        o_match = '0;
        for (int l = 1; l <= MAX_PATTERN; l++) begin
            eq = 1'b1;
            for (int k = 0; k < l; k++) begin
                if (i_hist[l-1-k] != i_pattern[8*k +: 8]) begin
                    eq = 1'b0;
                end
            end
            if (i_len == LEN_W'(l)) begin
                o_match.hit          = eq;
                o_match.before_alnum = is_alnum(i_hist[l]);
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/whole_word_substring_counter_top.sv
// Path: a terminator byte is first registered in the input register; its result is then
// registered in the output register once that register is free or being read.
// Throughput: one byte per cycle; the input register holds a terminator only while
// the previous result still sits unread in the output register and is not being read.
// Each byte's match check and count update is one pass through the compare logic.
// Reset (synchronous, active low) empties both registers, clears the string state and
// restores the configuration defaults.
// ----------------------------------------------------------------------------
// whole_word_substring_counter_top
// Counts leftmost, non-overlapping whole-word matches of a configured pattern
// in a zero-terminated byte string and reports the count at the terminator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "whole_word_substring_counter_top_assert.svh"

module whole_word_substring_counter_top #(
    parameter int MAX_PATTERN   = wwsc_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = wwsc_pkg::POSITION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [wwsc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wwsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // byte input
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  wwsc_pkg::t_byte                   i_char_in,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [wwsc_pkg::COUNT_W-1:0]      o_word_count,
    output logic                              o_range_error
);
    import wwsc_pkg::*;

    localparam int CW = (POSITION_BITS > WIN_W) ? POSITION_BITS : WIN_W;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    // configuration registers
    logic [PATTERN_W-1:0] r_pattern;
    logic [LEN_W-1:0]     r_plen;
    logic [WIN_W-1:0]     r_ws;
    logic [WIN_W-1:0]     r_we;
    logic                 r_eal;

    // input stage
    logic                 r_s1_valid;
    t_byte                r_char;

    // string state
    t_byte                     r_hist [MAX_PATTERN];
    logic [POSITION_BITS-1:0]  r_pos, n_pos;
    logic [POSITION_BITS-1:0]  r_nas, n_nas;
    logic [COUNT_W-1:0]        r_cnt, n_cnt;
    logic                      r_pend, n_pend;
    logic [POSITION_BITS-1:0]  r_pend_end, n_pend_end;

    // output register
    logic                 r_out_valid;
    logic [COUNT_W-1:0]   r_word_count;
    logic                 r_range_error;

    logic s1_term, s1_go, s2_emit, in_acc;

    t_byte                     hist_now [MAX_PATTERN+1];
    t_match                    s_match;
    logic [LEN_W-1:0]          l_len;
    logic                      l_pend_ok;
    logic [COUNT_W-1:0]        l_cnt_inc;
    logic [CW-1:0]             l_eff_end;
    logic                      l_err;
    logic                      l_adv;
    logic [POSITION_BITS-1:0]  l_pos_inc;
    logic [CW-1:0]             l_p;
    logic                      l_found;
    logic                      l_take;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_plen    <= LEN_W'(1);
            r_ws      <= '0;
            r_we      <= '1;
            r_eal     <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PATTERN_BYTES:  r_pattern <= i_cfg_data[PATTERN_W-1:0];
                CFG_PATTERN_LENGTH: r_plen    <= i_cfg_data[LEN_W-1:0];
                CFG_WINDOW_START:   r_ws      <= i_cfg_data[WIN_W-1:0];
                CFG_WINDOW_END:     r_we      <= i_cfg_data[WIN_W-1:0];
                CFG_END_AT_LENGTH:  r_eal     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign s1_term    = (r_char == '0);
    // a terminator may only move on when the result slot is free or being read
    assign s1_go      = r_s1_valid && (!s1_term || !r_out_valid || i_out_ready);
    assign s2_emit    = s1_go && s1_term;
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_acc     = i_in_valid && o_in_ready;

    // ---------------- compare ----------------
    always_comb begin
        hist_now[0] = r_char;
        for (int i = 1; i <= MAX_PATTERN; i++) begin
            hist_now[i] = r_hist[i-1];
        end
    end

    assign l_len = (r_plen > MAX_LEN) ? MAX_LEN : r_plen;

    wwsc_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .i_hist    (hist_now),
        .i_pattern (r_pattern),
        .i_len     (l_len),
        .o_match   (s_match)
    );

    // ---------------- per-byte update ----------------
    always_comb begin
        // waiting match is settled by the byte after it (or the window boundary)
        l_pend_ok = r_pend && ((!r_eal && CW'(r_pend_end) >= CW'(r_we)) ||
                               !is_alnum(r_char));
        l_cnt_inc = r_cnt + COUNT_W'(l_pend_ok && (r_cnt != COUNT_MAX));

        l_eff_end = r_eal ? CW'(r_pos) : CW'(r_we);
        l_err     = CW'(r_ws) > l_eff_end;

        l_adv     = (r_pos != POS_MAX) && (l_len != '0);
        l_pos_inc = r_pos + POSITION_BITS'(1);
        l_p       = CW'(l_pos_inc) - CW'(l_len);   // match start, valid once enough bytes
        l_found   = l_adv && (CW'(l_pos_inc) >= CW'(l_len)) && s_match.hit &&
                    (l_p >= CW'(r_ws)) && (l_p >= CW'(r_nas)) &&
                    (r_eal || (l_p < CW'(r_we)));
        l_take    = l_found && ((l_p == '0) || !s_match.before_alnum);

        n_pos      = r_pos;
        n_nas      = r_nas;
        n_cnt      = r_cnt;
        n_pend     = r_pend;
        n_pend_end = r_pend_end;
        if (s1_go) begin
            if (s1_term) begin
                n_pos  = '0;
                n_nas  = '0;
                n_cnt  = '0;
                n_pend = 1'b0;
            end else begin
                n_cnt  = l_cnt_inc;
                n_pend = l_take;
                if (l_adv) begin
                    n_pos = l_pos_inc;
                end
                if (l_found) begin
                    n_nas = l_pos_inc;   // rejected matches still skip ahead
                end
                if (l_take) begin
                    n_pend_end = l_pos_inc;
                end
            end
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_nas       <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_pos  <= n_pos;
            r_nas  <= n_nas;
            r_cnt  <= n_cnt;
            r_pend <= n_pend;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_char <= i_char_in;
        end
        r_pend_end <= n_pend_end;
        if (s1_go && !s1_term) begin
            r_hist[0] <= r_char;
            for (int i = 1; i < MAX_PATTERN; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
        if (s2_emit) begin
            r_word_count  <= l_err ? '0 : l_cnt_inc;
            r_range_error <= l_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_word_count  = r_word_count;
    assign o_range_error = r_range_error;

    // ---------------- assertions ----------------
    `WWSC_ASSERT_IMP(a_emit_slot_free, i_clk, i_rst_n, s2_emit, !r_out_valid || i_out_ready)
    `WWSC_ASSERT_IMP(a_err_zero_count, i_clk, i_rst_n, r_out_valid && r_range_error, r_word_count == '0)
    `WWSC_ASSERT_IMP(a_skip_not_ahead, i_clk, i_rst_n, 1'b1, r_nas <= r_pos)
    `WWSC_ASSERT_IMP(a_pend_at_pos, i_clk, i_rst_n, r_pend, (r_pend_end == r_pos) && (r_nas == r_pos))
    `WWSC_ASSERT_NEXT(a_term_held, i_clk, i_rst_n, r_s1_valid && s1_term && !s1_go, r_s1_valid && s1_term)

endmodule

`default_nettype wire

>>> bench/wwsc_count_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Whole-word count checker
// Watches the register port and both item channels, predicts the count and
// range flag of every string and compares them with what the block reports.
// ----------------------------------------------------------------------------
module wwsc_count_check (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wwsc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wwsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  wwsc_pkg::t_byte                   i_char_in,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [wwsc_pkg::COUNT_W-1:0]      i_word_count,
    input  logic                              i_range_error,
    output int                                o_errors,
    output int                                o_outstanding,
    output int                                o_strings,
    output int                                o_strings_counted,
    output int                                o_range_flags
);
    import wwsc_pkg::*;

    localparam int HIST     = 9;
    localparam int PLEN_MAX = 8;
    localparam int POS_SAT  = 65535;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               range_err;
    } t_tally;

    // register copy
    logic [63:0] pat;
    logic [3:0]  plen;
    logic [15:0] wstart;
    logic [15:0] wend;
    logic        eal;

    // string state
    t_byte hist [HIST];
    int    pos;
    int    next_start;
    int    tally;
    bit    pend;
    int    pend_end;

    t_tally counts_due [$];
    int errors          = 0;
    int strings         = 0;
    int strings_counted = 0;
    int range_flags     = 0;
    int outstanding     = 0;

    assign o_errors          = errors;
    assign o_outstanding     = outstanding;
    assign o_strings         = strings;
    assign o_strings_counted = strings_counted;
    assign o_range_flags     = range_flags;

    function automatic bit word_char(t_byte c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    task automatic clear_string();
        foreach (hist[i]) hist[i] = '0;
        pos        = 0;
        next_start = 0;
        tally      = 0;
        pend       = 1'b0;
        pend_end   = 0;
    endtask

    task automatic scan_byte(t_byte c);
        int     len;
        int     p;
        bit     hit;
        t_tally r;
        len = (plen > PLEN_MAX) ? PLEN_MAX : int'(plen);

        // a waiting match is settled by whatever byte follows it
        if (pend) begin
            if ((!eal && pend_end >= int'(wend)) || !word_char(c)) begin
                if (tally < int'(COUNT_MAX)) tally++;
            end
            pend = 1'b0;
        end

        if (c == 8'h00) begin
            r.range_err = int'(wstart) > (eal ? pos : int'(wend));
            r.count     = r.range_err ? '0 : tally[COUNT_W-1:0];
            counts_due.push_back(r);
            clear_string();
            return;
        end

        for (int i = HIST - 1; i > 0; i--) hist[i] = hist[i-1];
        hist[0] = c;

        // saturated position: the byte only resolves, never starts a match
        if (pos >= POS_SAT || len == 0) return;
        pos++;
        if (pos < len) return;

        hit = 1'b1;
        for (int k = 0; k < len; k++) begin
            if (hist[len-1-k] != pat[8*k +: 8]) hit = 1'b0;
        end
        if (!hit) return;

        p = pos - len;
        if (p < int'(wstart) || p < next_start) return;
        if (!eal && p >= int'(wend)) return;

        // found matches skip ahead even if the word check rejects them
        next_start = p + len;
        if (p == 0 || !word_char(hist[len])) begin
            pend     = 1'b1;
            pend_end = p + len;
        end
    endtask

    task automatic check_result();
        t_tally want;
        if (counts_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: word_count %0d range_error %0b",
                     $time, i_word_count, i_range_error);
            return;
        end
        want = counts_due.pop_front();
        strings++;
        if (want.count != 0) strings_counted++;
        if (want.range_err) range_flags++;
        if (i_word_count !== want.count) begin
            errors++;
            $display("%0t: word_count mismatch: expected %0d, actual %0d",
                     $time, want.count, i_word_count);
        end
        if (i_range_error !== want.range_err) begin
            errors++;
            $display("%0t: range_error mismatch: expected %0b, actual %0b",
                     $time, want.range_err, i_range_error);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pat    = '0;
            plen   = 4'd1;
            wstart = '0;
            wend   = 16'hFFFF;
            eal    = 1'b1;
            clear_string();
            counts_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_result();
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_PATTERN_BYTES:  pat    = i_cfg_data;
                    CFG_PATTERN_LENGTH: plen   = i_cfg_data[3:0];
                    CFG_WINDOW_START:   wstart = i_cfg_data[15:0];
                    CFG_WINDOW_END:     wend   = i_cfg_data[15:0];
                    CFG_END_AT_LENGTH:  eal    = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) scan_byte(i_char_in);
        end
        outstanding = counts_due.size();
    end

endmodule

>>> bench/whole_word_substring_counter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Whole-word substring counter testbench
// Directed strings for the corner cases, then random word-like strings over
// several register settings and idle/stall phases; checking is in the monitor.
// ----------------------------------------------------------------------------
module whole_word_substring_counter_top_tb;
    import wwsc_pkg::*;

    localparam int CLK_NS       = 12;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1800;
    localparam int PHASES       = 8;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN        = 4;
    localparam int LIMIT_CYCLES = 2_000_000;

    localparam t_byte WORD_LETTERS  [4]  = '{8'h61, 8'h62, 8'h31, 8'h5A};
    localparam t_byte PATTERN_CHARS [5]  = '{8'h61, 8'h62, 8'h31, 8'h2D, 8'h20};
    // bytes either side of the letter and digit ranges
    localparam t_byte ALNUM_EDGES   [12] = '{8'h2F, 8'h30, 8'h39, 8'h3A, 8'h40, 8'h41,
                                             8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_cfg_we   = 1'b0;
    t_cfg_idx               cfg_idx    = CFG_PATTERN_BYTES;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    t_byte                  i_char_in  = '0;
    logic                   i_out_ready = 1'b0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [COUNT_W-1:0]     o_word_count;
    logic                   o_range_error;

    int errors;
    int outstanding;
    int strings;
    int strings_counted;
    int range_flags;

    logic [63:0] cur_pat        = '0;
    logic [3:0]  cur_len        = 4'd1;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          items_sent     = 0;
    bit          hold_go        = 1'b0;
    bit          hold_seen      = 1'b0;
    int          hold_left      = 0;

    whole_word_substring_counter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_char_in     (i_char_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_word_count  (o_word_count),
        .o_range_error (o_range_error)
    );

    wwsc_count_check u_count_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_char_in         (i_char_in),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_word_count      (o_word_count),
        .i_range_error     (o_range_error),
        .o_errors          (errors),
        .o_outstanding     (outstanding),
        .o_strings         (strings),
        .o_strings_counted (strings_counted),
        .o_range_flags     (range_flags)
    );

    initial begin
        forever #(CLK_NS / 2) i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_NS);
        $display("whole_word_substring_counter_top_tb failed");
        $finish;
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_go != hold_seen) begin
            hold_seen = hold_go;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_byte(t_byte b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_text(string txt, bit terminate);
        for (int i = 0; i < txt.len(); i++) send_byte(t_byte'(txt[i]));
        if (terminate) send_byte(8'h00);
    endtask

    // drop valid and wait until every count is back and the pipe is empty
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic put_reg(t_cfg_idx idx, logic [63:0] v);
        i_cfg_we   <= 1'b1;
        cfg_idx    <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
    endtask

    task automatic program_regs(logic [63:0] pat, logic [3:0] len, logic [15:0] ws,
                                logic [15:0] wend, logic eal);
        cur_pat = pat;
        cur_len = len;
        put_reg(CFG_PATTERN_BYTES, pat);
        put_reg(CFG_PATTERN_LENGTH, 64'(len));
        put_reg(CFG_WINDOW_START, 64'(ws));
        put_reg(CFG_WINDOW_END, 64'(wend));
        put_reg(CFG_END_AT_LENGTH, 64'(eal));
        i_cfg_we <= 1'b0;
    endtask

    task automatic program_phase(int ph);
        logic [63:0] pat;
        logic [3:0]  len;
        logic [15:0] ws;
        logic [15:0] wend;
        logic        eal;
        for (int k = 0; k < 8; k++) begin
            pat[8*k +: 8] = ($urandom_range(4) == 0) ? t_byte'($urandom_range(1, 255))
                                                     : PATTERN_CHARS[$urandom_range(0, 4)];
        end
        len  = 4'($urandom_range(1, 8));
        ws   = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 12)) : 16'd0;
        wend = ($urandom_range(1) == 0) ? 16'($urandom_range(0, 30)) : 16'hFFFF;
        eal  = 1'($urandom_range(1));
        case (ph)
            0: begin
                len  = 4'd1;
                ws   = 16'd0;
                wend = 16'hFFFF;
                eal  = 1'b1;
            end
            1: begin
                len  = 4'd8;
                wend = 16'd0;
                eal  = 1'b0;
            end
            2: ws = 16'hFFFF;
            3: pat = '1;
            default: ;
        endcase
        program_regs(pat, len, ws, wend, eal);
    endtask

    // mostly words, separators and copies of the pattern; some cut-off patterns
    // and some plain noise
    task automatic send_random_string();
        t_byte s [$];
        int    eff;
        int    cut;
        eff = (cur_len > 8) ? 8 : int'(cur_len);
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(0, 16)) s.push_back(t_byte'($urandom_range(1, 255)));
        end else begin
            repeat ($urandom_range(0, 7)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        for (int k = 0; k < eff; k++) begin
                            if (cur_pat[8*k +: 8] != 8'h00) s.push_back(cur_pat[8*k +: 8]);
                        end
                    end
                    4: begin
                        cut = (eff > 1) ? $urandom_range(1, eff - 1) : 0;
                        for (int k = 0; k < cut; k++) begin
                            if (cur_pat[8*k +: 8] != 8'h00) s.push_back(cur_pat[8*k +: 8]);
                        end
                    end
                    5, 6: begin
                        repeat ($urandom_range(1, 3))
                            s.push_back(WORD_LETTERS[$urandom_range(0, 3)]);
                    end
                    default: begin
                        case ($urandom_range(0, 3))
                            0: s.push_back(8'h20);
                            1: s.push_back(8'h2E);
                            2: s.push_back(t_byte'($urandom_range(8'h80, 8'hFF)));
                            default: s.push_back(ALNUM_EDGES[$urandom_range(0, 11)]);
                        endcase
                    end
                endcase
            end
        end
        foreach (s[i]) send_byte(s[i]);
        send_byte(8'h00);
    endtask

    initial begin
        int base;
        int phase_base;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset pattern is a zero byte, which no string byte can equal
        send_text("ab", 1'b1);
        send_text("", 1'b1);
        settle();

        program_regs(64'h6261, 4'd2, 16'd0, 16'hFFFF, 1'b1);
        send_text("ab-ab", 1'b1);
        send_text("abab", 1'b1);   // leftmost hit rejected, next hit rejected as it follows a letter
        settle();

        // oversized length saturates to eight bytes
        program_regs(64'h6867_6665_6463_6261, 4'd15, 16'd0, 16'hFFFF, 1'b1);
        send_text("abcdefgh", 1'b1);
        settle();
        program_regs(64'h6867_6665_6463_6261, 4'd0, 16'd0, 16'hFFFF, 1'b1);
        send_text("a", 1'b1);
        settle();

        // window start beyond the string with a fixed end: no error
        program_regs(64'h6261, 4'd2, 16'd10, 16'd20, 1'b0);
        send_text("ab", 1'b1);
        settle();
        program_regs(64'h6261, 4'd2, 16'd5, 16'hFFFF, 1'b1);
        send_text("ab", 1'b1);
        settle();
        program_regs(64'h6261, 4'd2, 16'd0, 16'd2, 1'b0);
        send_text("ab ab", 1'b1);
        settle();

        program_regs(64'hFF, 4'd1, 16'd0, 16'hFFFF, 1'b1);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h00);
        settle();

        // pattern changed part way through a string
        program_regs(64'h61, 4'd1, 16'd0, 16'hFFFF, 1'b1);
        send_text("a ", 1'b0);
        settle();
        program_regs(64'h62, 4'd1, 16'd0, 16'hFFFF, 1'b1);
        send_text("b", 1'b1);
        settle();

        base = items_sent;
        for (int ph = 0; items_sent - base < RANDOM_ITEMS; ph++) begin
            program_phase(ph);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            // long hold-off with the sender still busy: input backs up
            if (ph % 4 == 2) hold_go = ~hold_go;
            phase_base = items_sent;
            while (items_sent - phase_base < RANDOM_ITEMS / PHASES) send_random_string();
            settle();
        end

        $display("covered %0d strings in %0d bytes: %0d non-zero counts, %0d range errors",
                 strings, items_sent, strings_counted, range_flags);
        $display("pattern lengths 0 to 15, window extremes, live register change, idle/stall phases");
        if (errors == 0 && outstanding == 0) begin
            $display("whole_word_substring_counter_top_tb passed");
        end else begin
            $display("whole_word_substring_counter_top_tb failed");
        end
        $finish;
    end

endmodule
